// File: src/ita_pkg.sv
package ita_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int IN_WIDTH    = 64;

	// decimal digits needed for VALUE_WIDTH bits (log10(2) ~ 0.30103), hex digits
	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103 + 99999) / 100000;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int BCD_W      = NUM_DIGITS * 4;
	localparam int CNT_W      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_SDEC = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_A     = 8'h61;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_X     = 8'h78;

	typedef enum logic [1:0] {
		SEL_MINUS,
		SEL_ZERO,
		SEL_X,
		SEL_DIGIT
	} char_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SIGN,
		ST_PFX0,
		ST_PFXX,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      shift;
		char_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic hex;
		logic conv_done;
		logic top_zero;
		logic one_left;
	} stat_t;

endpackage

// File: src/ita_in_if.sv
interface ita_in_if
	import ita_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [IN_WIDTH-1:0] value;
	logic [1:0]          mode;

	modport source (output valid, output value, output mode, input ready);
	modport sink   (input valid, input value, input mode, output ready);
endinterface

// File: src/ita_out_if.sv
interface ita_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: src/ita_dp.sv
module ita_dp
	import ita_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [IN_WIDTH-1:0] value,
	input  logic [1:0]          mode,
	output logic [7:0]          out_char,
	output logic                last
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   neg_q;
	logic                   hex_q;

	logic [VALUE_WIDTH-1:0] v_in;
	logic                   neg_in;
	logic                   hex_in;
	logic [3:0]             top_digit;
	logic [7:0]             digit_char;

	assign v_in   = value[VALUE_WIDTH-1:0];
	assign hex_in = (mode == MODE_HEX);
	assign neg_in = (mode == MODE_SDEC) && v_in[VALUE_WIDTH-1];

	// add 3 to every digit of 5 or more before the doubling shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= neg_in ? (VALUE_WIDTH'(0) - v_in) : v_in;
			bcd_q <= hex_in ? BCD_W'(v_in) : '0;
		end else if (cmd.conv_step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			hex_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= CNT_W'(VALUE_WIDTH - 1);
			rem_q <= REM_W'(NUM_DIGITS);
			neg_q <= neg_in;
			hex_q <= hex_in;
		end else begin
			if (cmd.conv_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.shift) begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		if (top_digit < 4'd10) begin
			digit_char = ASCII_ZERO + {4'h0, top_digit};
		end else begin
			digit_char = ASCII_A + {4'h0, top_digit} - 8'd10;
		end
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_MINUS: out_char = ASCII_MINUS;
			SEL_ZERO:  out_char = ASCII_ZERO;
			SEL_X:     out_char = ASCII_X;
			SEL_DIGIT: out_char = digit_char;
			default:   out_char = digit_char;
		endcase
	end

	assign last = (cmd.sel == SEL_DIGIT) && stat.one_left;

	assign stat.neg       = neg_q;
	assign stat.hex       = hex_q;
	assign stat.conv_done = (cnt_q == '0);
	assign stat.top_zero  = (top_digit == 4'h0);
	assign stat.one_left  = (rem_q == REM_W'(1));

	a_no_rem_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> rem_q != '0)
		else $error("digit count underflow");

	a_no_conv_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> !hex_q)
		else $error("decimal conversion step in hex mode");

	a_load_sets_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> rem_q == REM_W'(NUM_DIGITS))
		else $error("digit count not loaded");

endmodule

// File: src/ita_ctrl.sv
module ita_ctrl
	import ita_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.shift     = 1'b0;
		cmd.sel       = SEL_DIGIT;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (stat.neg) begin
					state_d = ST_SIGN;
				end else if (stat.hex) begin
					state_d = ST_PFX0;
				end else begin
					state_d = ST_CONV;
				end
			end
			ST_SIGN: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_MINUS;
				if (out_ready) begin
					state_d = ST_CONV;
				end
			end
			ST_PFX0: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_ZERO;
				if (out_ready) begin
					state_d = ST_PFXX;
				end
			end
			ST_PFXX: begin
				out_valid = 1'b1;
				cmd.sel   = SEL_X;
				if (out_ready) begin
					state_d = ST_SKIP;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (stat.top_zero && !stat.one_left) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift = 1'b1;
					if (stat.one_left) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_conv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && !stat.conv_done) |=> state_q == ST_CONV)
		else $error("conversion left early");

	a_skip_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP && stat.one_left) |=> state_q == ST_EMIT)
		else $error("leading zero skip ran past last digit");

endmodule

// File: src/integer_to_ascii_formatter.sv
// Sequence: the request is accepted in idle, a dispatch state follows, then the prefix characters.
// Decimal: a double-dabble shift for each of the VALUE_WIDTH (64) bits, then the skip of up to 19 leading zeros.
// Hex: the skip drops 4 to 19 leading zero digits. Each character is then handed over when out is ready.
// Throughput: one request at a time; a new request is taken only back in idle, after the last character.
// Reset: arst_n asynchronous active low, returns the controller to idle; no clearing pass.
module integer_to_ascii_formatter
	import ita_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ita_in_if.sink     din,
	ita_out_if.source  dout
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;
	logic  out_valid;

	ita_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ita_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.value    (din.value),
		.mode     (din.mode),
		.out_char (dout.out_char),
		.last     (dout.last)
	);

	assign din.ready  = in_ready;
	assign dout.valid = out_valid;

endmodule

// File: dv/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;
	import ita_pkg::*;

	// mode 3 has no name in the package; the block treats it as unsigned decimal
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_OPS    = 260;
	localparam int DRAIN_CYCLES  = 120;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int MAX_PRINTED   = 20;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_beat_t;

	typedef struct {
		logic [IN_WIDTH-1:0] operand;
		logic [1:0]          sel_mode;
		string               text;
	} directed_row_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_SLOW
	} rx_style_t;

	logic clk = 1'b0;
	logic arst_n;

	ita_in_if  din ();
	ita_out_if dout ();

	integer_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	always #1 clk = ~clk;

	char_beat_t expected_chars[$];
	char_beat_t check_beat;
	int         error_count = 0;
	int         burst_left  = 0;
	int         cycle_count = 0;
	int         rx_cycle    = 0;
	rx_style_t  rx_style;

	// empty text: the expectation comes from the formatter model below
	directed_row_t directed_rows [22] = '{
		'{64'd0,                  MODE_UDEC,  "0"},
		'{64'd0,                  MODE_SDEC,  "0"},
		'{64'd0,                  MODE_HEX,   "0x0"},
		'{64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC,  "18446744073709551615"},
		'{64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC,  "-1"},
		'{64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX,   "0xffffffffffffffff"},
		'{64'h8000_0000_0000_0000, MODE_SDEC,  "-9223372036854775808"},
		'{64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC,  "9223372036854775807"},
		'{64'h8000_0000_0000_0000, MODE_UDEC,  "9223372036854775808"},
		'{64'h8AC7_2304_89E8_0000, MODE_UDEC,  "10000000000000000000"},
		'{64'd9,                  MODE_UDEC,  "9"},
		'{64'd10,                 MODE_UDEC,  "10"},
		'{64'd1,                  MODE_SDEC,  "1"},
		'{64'hFFFF_FFFF_FFFF_FFF6, MODE_SDEC,  "-10"},
		'{64'd15,                 MODE_HEX,   "0xf"},
		'{64'd16,                 MODE_HEX,   "0x10"},
		'{64'h0123_4567_89AB_CDEF, MODE_HEX,   "0x123456789abcdef"},
		'{64'h0000_0000_FFFF_FFFF, MODE_HEX,   "0xffffffff"},
		'{64'd0,                  MODE_SPARE, "0"},
		'{64'd1234567890,         MODE_SPARE, "1234567890"},
		'{64'hAAAA_AAAA_AAAA_AAAA, MODE_SPARE, ""},
		'{64'h5555_5555_5555_5555, MODE_SDEC,  ""}
	};

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("%0t ns mismatch: %s", $time, msg);
		error_count++;
	endtask

	// queue the characters of one operand as the block should print them
	function automatic void format_number(input logic [IN_WIDTH-1:0] operand,
			input logic [1:0] sel_mode);
		bit [63:0] width_mask;
		bit [63:0] mag;
		bit [63:0] base;
		bit [63:0] rem;
		bit [7:0]  digits[$];
		width_mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
		mag = operand & width_mask;
		base = (sel_mode == MODE_HEX) ? 64'd16 : 64'd10;
		if (sel_mode == MODE_SDEC && mag[VALUE_WIDTH-1]) begin
			expected_chars.push_back('{ASCII_MINUS, 1'b0});
			mag = (64'd0 - mag) & width_mask;
		end else if (sel_mode == MODE_HEX) begin
			expected_chars.push_back('{ASCII_ZERO, 1'b0});
			expected_chars.push_back('{ASCII_X, 1'b0});
		end
		do begin
			rem = mag % base;
			digits.push_front((rem < 10) ? ASCII_ZERO + 8'(rem) : ASCII_A + 8'(rem - 10));
			mag = mag / base;
		end while (mag != 0);
		foreach (digits[i])
			expected_chars.push_back('{digits[i], i == digits.size() - 1});
	endfunction

	task automatic send_operand(input logic [IN_WIDTH-1:0] operand, input logic [1:0] sel_mode,
			input string text);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 8);
				default: gap = $urandom_range(1, 150);
			endcase
			if (gap > 0) begin
				din.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		din.valid <= 1'b1;
		din.value <= operand;
		din.mode  <= sel_mode;
		do @(posedge clk); while (!din.ready);
		if (text.len() == 0) begin
			format_number(operand, sel_mode);
		end else begin
			for (int i = 0; i < text.len(); i++)
				expected_chars.push_back('{text[i], i == text.len() - 1});
		end
	endtask

	// hold the sender until every queued character has come out
	task automatic drain_results();
		din.valid <= 1'b0;
		burst_left = 0;
		while (expected_chars.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [IN_WIDTH-1:0] random_operand();
		logic [63:0] pow10;
		int          k;
		pow10 = 64'd1;
		case ($urandom_range(0, 9))
			0: return 64'($urandom_range(0, 20));
			1: begin
				k = $urandom_range(0, 63);
				case ($urandom_range(0, 2))
					0: return 64'd1 << k;
					1: return (64'd1 << k) - 64'd1;
					default: return ~(64'd1 << k);
				endcase
			end
			2: begin
				k = $urandom_range(1, 19);
				repeat (k) pow10 = pow10 * 64'd10;
				return pow10 + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: return 64'd0 - 64'($urandom_range(1, 1000));
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [1:0] random_mode();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick < 5)
			return MODE_UDEC;
		else if (pick < 10)
			return MODE_SDEC;
		else if (pick < 15)
			return MODE_HEX;
		return MODE_SPARE;
	endfunction

	// receiver: rotate through the four ready styles in turn, from steady to slow
	initial begin
		dout.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			rx_style = rx_style_t'((rx_cycle / 250) % 4);
			case (rx_style)
				RX_STEADY: dout.ready <= 1'b1;
				RX_COIN:   dout.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: dout.ready <= ($urandom_range(0, 7) != 0);
				default:   dout.ready <= (rx_cycle % 4 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last %b",
					dout.out_char, dout.last));
			end else begin
				check_beat = expected_chars.pop_front();
				if (dout.out_char !== check_beat.code)
					report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
						dout.out_char, check_beat.code));
				if (dout.last !== check_beat.last)
					report_mismatch($sformatf("last %b, want %b on char 0x%02h",
						dout.last, check_beat.last, check_beat.code));
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		din.valid = 1'b0;
		din.value = '0;
		din.mode  = MODE_UDEC;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_operand(directed_rows[i].operand, directed_rows[i].sel_mode,
				directed_rows[i].text);
		drain_results();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS / 2)
				drain_results();
			send_operand(random_operand(), random_mode(), "");
		end

		din.valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: integer_to_ascii_formatter.f
src/ita_pkg.sv
src/ita_in_if.sv
src/ita_out_if.sv
src/ita_dp.sv
src/ita_ctrl.sv
src/integer_to_ascii_formatter.sv
dv/tb_integer_to_ascii_formatter.sv
